// ----- rtl/indexed_stack_core_assert.svh -----
// Assertion macros shared by the stack core modules.
// Each macro expects the signals clk and rst_n in the module that uses it.
`ifndef INDEXED_STACK_CORE_ASSERT_SVH
`define INDEXED_STACK_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/isc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

    // Number of words the stack holds.
    localparam int STACK_DEPTH = 8;

    // Width of the word count, which must be able to hold STACK_DEPTH itself.
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    // Width of a memory address.
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Fixed field widths.
    localparam int POS_W  = 11;
    localparam int DATA_W = 32;

    // Operation codes.
    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_CHANGE = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_POS   = 2'd3
    } status_t;

    // Input word.
    typedef struct packed {
        mode_t                     mode;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  write_value;
    } request_t;

    // Result word.
    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        status_t                   status;
        logic [POS_W-1:0]          depth_used;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/isc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output isc_pkg::ctl_cmd_t      cmd
);

    `include "indexed_stack_core_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    // A word is taken when start is high and the block is not in its execute cycle.
    assign accept = start && !busy_reg;

    // Next state: an execute state, then a reply state that can overlap a new word.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                state_next = accept ? S_EXEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next == S_EXEC);
            done_reg  <= (state_next == S_REPLY);
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign cmd.load = accept;
    assign cmd.exec = (state_reg == S_EXEC);

    `ISC_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
    `ISC_ASSERT_NEXT(a_exec_done, busy, done, "execute cycle not followed by a result")
    `ISC_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted two cycles")

endmodule

`default_nettype wire

// ----- rtl/isc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isc_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire isc_pkg::ctl_cmd_t    cmd,
    input  wire isc_pkg::request_t    request,
    output isc_pkg::result_t          result
);

    `include "indexed_stack_core_assert.svh"

    // Word memory, no reset: only entries below the count are ever read.
    logic [isc_pkg::DATA_W-1:0] mem [isc_pkg::STACK_DEPTH];

    isc_pkg::mode_t                mode_reg;
    logic [isc_pkg::POS_W-1:0]     pos_reg;
    logic [isc_pkg::DATA_W-1:0]    wval_reg;
    logic [isc_pkg::CNT_W-1:0]     count_reg;
    logic [isc_pkg::CNT_W-1:0]     count_next;
    isc_pkg::status_t              status_reg;
    isc_pkg::status_t              status_next;
    logic                          ret_reg;
    logic                          ret_next;
    logic [isc_pkg::DATA_W-1:0]    rdata_reg;

    logic                          full;
    logic                          empty;
    logic                          pos_ok;
    logic [isc_pkg::CNT_W-1:0]     slot;
    logic [isc_pkg::CNT_W-1:0]     top;
    logic [isc_pkg::IDX_W-1:0]     mem_addr;
    logic                          mem_we;
    logic                          mem_re;

    // Capture the request word when it is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= request.mode;
            pos_reg  <= request.position;
            wval_reg <= request.write_value;
        end
    end

    // Stack conditions and the slot addressed by a position from the top.
    assign full   = (count_reg == isc_pkg::CNT_W'(isc_pkg::STACK_DEPTH));
    assign empty  = (count_reg == '0);
    assign pos_ok = (pos_reg != '0) && (pos_reg <= isc_pkg::POS_W'(count_reg));
    assign slot   = count_reg - isc_pkg::CNT_W'(pos_reg);
    assign top    = count_reg - isc_pkg::CNT_W'(1);

    // Operation decode: memory access, new count and status.
    always_comb
    begin
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = slot[isc_pkg::IDX_W-1:0];
        count_next  = count_reg;
        status_next = isc_pkg::ST_OK;
        ret_next    = 1'b0;
        case (mode_reg)
            isc_pkg::MODE_PUSH:
            begin
                mem_addr = count_reg[isc_pkg::IDX_W-1:0];
                if (full)
                begin
                    status_next = isc_pkg::ST_OVERFLOW;
                end
                else
                begin
                    mem_we     = cmd.exec;
                    count_next = count_reg + isc_pkg::CNT_W'(1);
                end
            end
            isc_pkg::MODE_POP:
            begin
                mem_addr = top[isc_pkg::IDX_W-1:0];
                if (empty)
                begin
                    status_next = isc_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    mem_re     = cmd.exec;
                    ret_next   = 1'b1;
                    count_next = top;
                end
            end
            isc_pkg::MODE_PEEK:
            begin
                if (!pos_ok)
                begin
                    status_next = isc_pkg::ST_BAD_POS;
                end
                else
                begin
                    mem_re   = cmd.exec;
                    ret_next = 1'b1;
                end
            end
            isc_pkg::MODE_CHANGE:
            begin
                if (!pos_ok)
                begin
                    status_next = isc_pkg::ST_BAD_POS;
                end
                else
                begin
                    mem_we = cmd.exec;
                end
            end
            default:
            begin
                status_next = isc_pkg::ST_OK;
            end
        endcase
    end

    // Single-port word memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= wval_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Count and result status, updated in the execute cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= isc_pkg::ST_OK;
            ret_reg    <= 1'b0;
        end
        else if (cmd.exec)
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            ret_reg    <= ret_next;
        end
    end

    // Result word; read data shows only for a successful pop or peek.
    assign result.read_value = ret_reg ? rdata_reg : '0;
    assign result.status     = status_reg;
    assign result.depth_used = isc_pkg::POS_W'(count_reg);

    `ISC_ASSERT_SAME(a_count_bound, 1'b1,
        count_reg <= isc_pkg::CNT_W'(isc_pkg::STACK_DEPTH), "word count above stack depth")
    `ISC_ASSERT_NEXT(a_count_hold, !cmd.exec, $stable(count_reg),
        "word count changed outside an execute cycle")
    `ISC_ASSERT_SAME(a_overflow_full, status_reg == isc_pkg::ST_OVERFLOW,
        count_reg == isc_pkg::CNT_W'(isc_pkg::STACK_DEPTH), "overflow reported on a stack not full")

endmodule

`default_nettype wire

// ----- rtl/indexed_stack_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// LIFO stack of signed 32-bit words with push, pop, and peek or change at a
// position counted from the top (1 is the top). A word is taken at a clock edge
// where start is high and busy is low. The operation runs in the following cycle
// against a single-port word memory. Its result is shown on result for exactly
// one cycle with done high, in the cycle after the execute cycle. The receiver
// cannot stall: result must be captured in the cycle that done is high. A new
// word may be started in that same cycle, but none is taken while busy is high
// in the execute cycle.

module indexed_stack_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire isc_pkg::request_t    request,
    output logic                      done,
    output isc_pkg::result_t          result
);

    isc_pkg::ctl_cmd_t cmd;

    // Sequencer for accept, execute and reply.
    isc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Word memory, count and result registers.
    isc_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

endmodule

`default_nettype wire

// ----- tb/indexed_stack_core_tb.sv -----
`timescale 1ns / 1ps

module indexed_stack_core_tb;

    import isc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 720;
    localparam int STEADY_WORDS  = 100;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    // Shadow copy of the stack, updated as each word is taken.
    logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
    int                       shadow_count = 0;

    // Results still owed by the block, oldest first.
    result_t pending_results [$];

    int error_count = 0;
    int cycle_count = 0;

    indexed_stack_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
        error_count++;
    endtask

    // Apply one operation to the shadow stack and return the result it should give.
    function automatic result_t apply_stack_op(input request_t req);
        result_t res;
        int      slot;
        res.read_value = '0;
        res.status     = ST_OK;
        case (req.mode)
            MODE_PUSH:
            begin
                if (shadow_count >= STACK_DEPTH)
                    res.status = ST_OVERFLOW;
                else
                begin
                    shadow_words[shadow_count] = req.write_value;
                    shadow_count++;
                end
            end
            MODE_POP:
            begin
                if (shadow_count == 0)
                    res.status = ST_UNDERFLOW;
                else
                begin
                    shadow_count--;
                    res.read_value = shadow_words[shadow_count];
                end
            end
            default:
            begin
                // Positions count from the top; zero and anything past the count are rejected.
                if (req.position == 0 || int'(req.position) > shadow_count)
                    res.status = ST_BAD_POS;
                else
                begin
                    slot = shadow_count - int'(req.position);
                    if (req.mode == MODE_PEEK)
                        res.read_value = shadow_words[slot];
                    else
                        shadow_words[slot] = req.write_value;
                end
            end
        endcase
        res.depth_used = POS_W'(shadow_count);
        return res;
    endfunction

    // Hold one word on the inputs until the block takes it.
    task automatic send_word(input mode_t mode, input int position,
                             input logic [DATA_W-1:0] value);
        request_t req;
        req.mode        = mode;
        req.position    = POS_W'(position);
        req.write_value = value;
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_stack_op(req));
    endtask

    // Leave start low for a burst of cycles, with junk on the request lines.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start   <= 1'b0;
        request <= request_t'({$urandom, $urandom});
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic maybe_pause(input int percent);
        if ($urandom_range(0, 99) < percent)
            pause_sender($urandom_range(1, 18));
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly valid positions, with zero, just-past-the-count and wild values mixed in.
    function automatic int random_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, (shadow_count > 0) ? shadow_count : 1);
        else if (roll < 82)
            return 0;
        else if (roll < 90)
            return $urandom_range(shadow_count + 1, STACK_DEPTH + 1);
        else
            return $urandom_range(0, 2047);
    endfunction

    task automatic send_random_word(input bit fill_bias, input int pause_percent);
        int    roll;
        mode_t mode;
        roll = $urandom_range(0, 99);
        if (fill_bias)
            mode = (roll < 50) ? MODE_PUSH : (roll < 65) ? MODE_POP :
                   (roll < 83) ? MODE_PEEK : MODE_CHANGE;
        else
            mode = (roll < 20) ? MODE_PUSH : (roll < 55) ? MODE_POP :
                   (roll < 78) ? MODE_PEEK : MODE_CHANGE;
        maybe_pause(pause_percent);
        send_word(mode, random_position(), random_value());
    endtask

    // Compare each result word with the oldest one owed.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", result.read_value, '0);
            else
            begin
                want = pending_results.pop_front();
                if (result.read_value !== want.read_value)
                    report_mismatch("read_value", result.read_value, want.read_value);
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
                if (result.depth_used !== want.depth_used)
                    report_mismatch("depth_used", 32'(result.depth_used), 32'(want.depth_used));
            end
        end
    end

    // Pop, peek and change on an empty stack all fail.
    task automatic test_empty_stack();
        send_word(MODE_POP, 0, '0);
        send_word(MODE_PEEK, 1, '0);
        maybe_pause(50);
        send_word(MODE_CHANGE, 0, 32'hFFFF_FFFF);
    endtask

    // Fill with the extreme values, then push once more into a full stack.
    task automatic test_fill_and_overflow();
        send_word(MODE_PUSH, 0, 32'h7FFF_FFFF);
        send_word(MODE_PUSH, 2047, 32'h8000_0000);
        send_word(MODE_PUSH, 0, 32'h0000_0000);
        maybe_pause(50);
        send_word(MODE_PUSH, 0, 32'hFFFF_FFFF);
        while (shadow_count < STACK_DEPTH)
            send_word(MODE_PUSH, 0, $urandom);
        send_word(MODE_PUSH, 0, 32'h1234_5678);
    endtask

    // Peek and change at the top, the bottom and past the ends of a full stack.
    task automatic test_indexed_access();
        send_word(MODE_PEEK, 1, '0);
        send_word(MODE_PEEK, STACK_DEPTH, '0);
        send_word(MODE_PEEK, STACK_DEPTH + 1, '0);
        send_word(MODE_PEEK, 2047, '0);
        maybe_pause(50);
        send_word(MODE_CHANGE, 1, 32'h5A5A_A5A5);
        send_word(MODE_CHANGE, STACK_DEPTH, 32'hA5A5_5A5A);
        send_word(MODE_CHANGE, 1024, 32'h0BAD_F00D);
        send_word(MODE_PEEK, 0, '0);
    endtask

    // Pops return the changed words; the last pop underflows.
    task automatic test_drain();
        while (shadow_count > 0)
        begin
            maybe_pause(20);
            send_word(MODE_POP, 0, $urandom);
        end
        send_word(MODE_POP, 0, '0);
    endtask

    // Random traffic that swings between filling and draining, with idle stretches.
    task automatic test_random_traffic();
        bit fill_bias;
        int pause_percent;
        int run_left;
        fill_bias = 1'b1;
        run_left  = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (run_left == 0)
            begin
                run_left      = $urandom_range(10, 40);
                fill_bias     = 1'($urandom_range(0, 1));
                pause_percent = ($urandom_range(0, 2) == 0) ? 0 : 35;
            end
            run_left--;
            send_random_word(fill_bias, pause_percent);
        end
    endtask

    // Back-to-back words with no idling at all.
    task automatic test_steady_stream();
        for (int n = 0; n < STEADY_WORDS; n++)
            send_random_word((n / 20) % 2 == 0, 0);
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_stack();
        test_fill_and_overflow();
        test_indexed_access();
        test_drain();
        test_random_traffic();
        test_steady_stream();

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/isc_pkg.sv
rtl/isc_ctrl.sv
rtl/isc_datapath.sv
rtl/indexed_stack_core.sv
tb/indexed_stack_core_tb.sv
